>>> sv/rscu_pkg.sv
`timescale 1ns / 1ps

package rscu_pkg;

  localparam int CNT_W_DEF = 64;
  localparam int TIME_W    = 24;
  localparam int FPS_W     = 26;
  localparam int WGT_W     = 16;
  localparam int DIV_NUM_W = 27;

  localparam logic [WGT_W-1:0]     WEIGHT_RST = 16'd6554;
  localparam logic [DIV_NUM_W-1:0] FPS_NUM    = 27'd65536000;
  localparam logic [31:0]          DIV3_MAGIC = 32'hAAAA_AAAB;

  localparam logic [2:0] OP_DRAW     = 3'd0;
  localparam logic [2:0] OP_INDIRECT = 3'd1;
  localparam logic [2:0] OP_COMPUTE  = 3'd2;
  localparam logic [2:0] OP_RAYTRACE = 3'd3;
  localparam logic [2:0] OP_FRAME    = 3'd4;

  localparam logic [2:0] MODE_TRI_LIST  = 3'd3;
  localparam logic [2:0] MODE_TRI_STRIP = 3'd4;
  localparam logic [2:0] MODE_TRI_FAN   = 3'd5;

  typedef struct packed {
    logic [2:0]        operation;
    logic [2:0]        draw_mode;
    logic [31:0]       element_count;
    logic [31:0]       instance_count;
    logic [31:0]       command_count;
    logic [TIME_W-1:0] frame_time;
  } rscu_in_t;

  typedef struct packed {
    logic [TIME_W-1:0] avg_frame_time;
    logic [FPS_W-1:0]  frames_per_second;
    logic [63:0]       draws_in_frame;
    logic [63:0]       direct_draws_in_frame;
    logic [63:0]       indirect_draws_in_frame;
    logic [63:0]       indirect_commands_in_frame;
    logic [63:0]       vertices_in_frame;
    logic [63:0]       triangles_in_frame;
    logic [63:0]       instances_in_frame;
    logic [63:0]       compute_in_frame;
    logic [63:0]       raytrace_in_frame;
    logic [31:0]       frame_index;
  } rscu_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;
    logic tri_mul;
    logic acc_draw;
    logic smooth;
    logic div_start;
    logic emit;
  } rscu_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic draw_go;
    logic frame_go;
    logic div_done;
    logic out_free;
  } rscu_sts_t;

endpackage

>>> sv/rscu_div.sv
`timescale 1ns / 1ps

module rscu_div import rscu_pkg::*; #(
  parameter int NUM_W = DIV_NUM_W,
  parameter int DEN_W = TIME_W
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quot_o
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] q_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DEN_W:0]   trial;
  logic             ge;

  // One quotient bit per cycle, restoring form.
  assign trial = {rem_r, q_r[NUM_W-1]};
  assign ge    = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start_i) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_i) begin
      q_r   <= num_i;
      den_r <= den_i;
      rem_r <= '0;
    end else if (busy_r) begin
      q_r   <= {q_r[NUM_W-2:0], ge};
      rem_r <= ge ? DEN_W'(trial - {1'b0, den_r}) : trial[DEN_W-1:0];
    end
  end

  assign done_o = done_r;
  assign quot_o = q_r;

endmodule

>>> sv/rscu_dp.sv
`timescale 1ns / 1ps

module rscu_dp import rscu_pkg::*; #(
  parameter int COUNTER_WIDTH = CNT_W_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  rscu_cmd_t        cmd_i,
  output rscu_sts_t        sts_o,
  input  rscu_in_t         in_data_i,
  input  logic             cfg_we_i,
  input  logic [WGT_W-1:0] cfg_wdata_i,
  input  logic             out_stall_i,
  output logic             out_valid_o,
  output rscu_out_t        out_data_o
);

  localparam int CW      = COUNTER_WIDTH;
  localparam int CNT_NUM = 9;
  localparam int C_DRAW  = 0;
  localparam int C_DIR   = 1;
  localparam int C_IND   = 2;
  localparam int C_CMD   = 3;
  localparam int C_VTX   = 4;
  localparam int C_TRI   = 5;
  localparam int C_INST  = 6;
  localparam int C_COMP  = 7;
  localparam int C_RAY   = 8;

  logic [CW-1:0]        cnt_r   [CNT_NUM];
  logic [CW-1:0]        cnt_nxt [CNT_NUM];
  logic [WGT_W-1:0]     weight_r;
  logic [TIME_W-1:0]    smoothed_r;
  logic [TIME_W-1:0]    smoothed_nxt;
  logic [31:0]          frame_cnt_r;
  logic                 out_valid_r;
  logic                 out_valid_nxt;
  rscu_out_t            out_r;
  rscu_in_t             in_r;
  logic [63:0]          vprod_r;
  logic [63:0]          tq_r;
  logic [63:0]          tprod_r;
  logic [40:0]          pa_r;
  logic [39:0]          pb_r;
  logic [WGT_W:0]       wcomp;
  logic [41:0]          blend;
  logic [31:0]          tri_prims;
  logic [DIV_NUM_W-1:0] quot;
  logic                 div_done;
  logic [FPS_W-1:0]     fps;

  assign wcomp = 17'd65536 - {1'b0, weight_r};
  assign blend = 42'(pa_r) + 42'(pb_r) + 42'd32768;

  always_comb begin
    case (in_r.draw_mode)
      MODE_TRI_LIST: tri_prims = {1'b0, tq_r[63:33]};
      MODE_TRI_STRIP, MODE_TRI_FAN: begin
        tri_prims = (in_r.element_count > 32'd2) ? in_r.element_count - 32'd2 : 32'd0;
      end
      default: tri_prims = 32'd0;
    endcase
  end

  // Counter updates: simple events at accept, draws after their products settle, all cleared at a snapshot.
  always_comb begin
    for (int i = 0; i < CNT_NUM; i++) begin
      cnt_nxt[i] = cnt_r[i];
    end
    if (cmd_i.emit) begin
      for (int i = 0; i < CNT_NUM; i++) begin
        cnt_nxt[i] = '0;
      end
    end else if (cmd_i.acc_draw) begin
      cnt_nxt[C_DRAW] = cnt_r[C_DRAW] + CW'(1);
      cnt_nxt[C_DIR]  = cnt_r[C_DIR] + CW'(1);
      cnt_nxt[C_VTX]  = cnt_r[C_VTX] + vprod_r[CW-1:0];
      cnt_nxt[C_TRI]  = cnt_r[C_TRI] + tprod_r[CW-1:0];
      cnt_nxt[C_INST] = cnt_r[C_INST] + CW'(in_r.instance_count);
    end else if (cmd_i.take) begin
      case (in_data_i.operation)
        OP_INDIRECT: begin
          cnt_nxt[C_DRAW] = cnt_r[C_DRAW] + CW'(1);
          cnt_nxt[C_IND]  = cnt_r[C_IND] + CW'(1);
          cnt_nxt[C_CMD]  = cnt_r[C_CMD] + CW'(in_data_i.command_count);
        end
        OP_COMPUTE:  cnt_nxt[C_COMP] = cnt_r[C_COMP] + CW'(1);
        OP_RAYTRACE: cnt_nxt[C_RAY]  = cnt_r[C_RAY] + CW'(1);
        default: ;
      endcase
    end
  end

  always_comb begin
    smoothed_nxt = smoothed_r;
    if (cmd_i.smooth && in_r.frame_time != '0) begin
      smoothed_nxt = (smoothed_r == '0) ? in_r.frame_time : blend[39:16];
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd_i.emit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CNT_NUM; i++) begin
        cnt_r[i] <= '0;
      end
      weight_r    <= WEIGHT_RST;
      smoothed_r  <= '0;
      frame_cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      for (int i = 0; i < CNT_NUM; i++) begin
        cnt_r[i] <= cnt_nxt[i];
      end
      if (cfg_we_i) begin
        weight_r <= cfg_wdata_i;
      end
      smoothed_r  <= smoothed_nxt;
      out_valid_r <= out_valid_nxt;
      if (cmd_i.emit) begin
        frame_cnt_r <= frame_cnt_r + 32'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.take) begin
      in_r    <= in_data_i;
      vprod_r <= in_data_i.element_count * in_data_i.instance_count;
      tq_r    <= in_data_i.element_count * DIV3_MAGIC;
      pa_r    <= smoothed_r * wcomp;
      pb_r    <= in_data_i.frame_time * weight_r;
    end
    if (cmd_i.tri_mul) begin
      tprod_r <= tri_prims * in_r.instance_count;
    end
    if (cmd_i.emit) begin
      out_r.avg_frame_time             <= smoothed_r;
      out_r.frames_per_second          <= fps;
      out_r.draws_in_frame             <= 64'(cnt_r[C_DRAW]);
      out_r.direct_draws_in_frame      <= 64'(cnt_r[C_DIR]);
      out_r.indirect_draws_in_frame    <= 64'(cnt_r[C_IND]);
      out_r.indirect_commands_in_frame <= 64'(cnt_r[C_CMD]);
      out_r.vertices_in_frame          <= 64'(cnt_r[C_VTX]);
      out_r.triangles_in_frame         <= 64'(cnt_r[C_TRI]);
      out_r.instances_in_frame         <= 64'(cnt_r[C_INST]);
      out_r.compute_in_frame           <= 64'(cnt_r[C_COMP]);
      out_r.raytrace_in_frame          <= 64'(cnt_r[C_RAY]);
      out_r.frame_index                <= frame_cnt_r + 32'd1;
    end
  end

  rscu_div #(
    .NUM_W(DIV_NUM_W),
    .DEN_W(TIME_W)
  ) u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start_i(cmd_i.div_start),
    .num_i  (FPS_NUM + DIV_NUM_W'(smoothed_r[TIME_W-1:1])),
    .den_i  (smoothed_r),
    .done_o (div_done),
    .quot_o (quot)
  );

  assign fps = (smoothed_r == '0) ? '0 : quot[FPS_W-1:0];

  always_comb begin
    sts_o.draw_go  = (in_data_i.operation == OP_DRAW) &&
                     (in_data_i.element_count != '0) && (in_data_i.instance_count != '0);
    sts_o.frame_go = (in_data_i.operation == OP_FRAME);
    sts_o.div_done = div_done;
    sts_o.out_free = !out_valid_r || !out_stall_i;
  end

  assign out_valid_o = out_valid_r;
  assign out_data_o  = out_r;

`ifndef ASSERT_OFF
  a_valid_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd_i.emit))
    else $error("result became valid without a snapshot");

  a_clear_on_emit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.emit |=> (cnt_r[C_DRAW] == '0) && (cnt_r[C_VTX] == '0) && (cnt_r[C_RAY] == '0))
    else $error("counters not cleared after snapshot");

  a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.emit |=> frame_cnt_r == $past(frame_cnt_r) + 32'd1)
    else $error("frame number did not advance by one");
`endif

endmodule

>>> sv/rscu_ctrl.sv
`timescale 1ns / 1ps

module rscu_ctrl import rscu_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  rscu_sts_t sts_i,
  output rscu_cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_TRI    = 3'd1;
  localparam logic [2:0] S_ACC    = 3'd2;
  localparam logic [2:0] S_SMOOTH = 3'd3;
  localparam logic [2:0] S_FPS    = 3'd4;
  localparam logic [2:0] S_WAIT   = 3'd5;
  localparam logic [2:0] S_EMIT   = 3'd6;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic       take;

  assign take = in_valid_i && (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (take && sts_i.draw_go) begin
          state_nxt = S_TRI;
        end else if (take && sts_i.frame_go) begin
          state_nxt = S_SMOOTH;
        end
      end
      S_TRI:    state_nxt = S_ACC;
      S_ACC:    state_nxt = S_IDLE;
      S_SMOOTH: state_nxt = S_FPS;
      S_FPS:    state_nxt = S_WAIT;
      S_WAIT: begin
        if (sts_i.div_done) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd_o.take      = take;
    cmd_o.tri_mul   = (state_r == S_TRI);
    cmd_o.acc_draw  = (state_r == S_ACC);
    cmd_o.smooth    = (state_r == S_SMOOTH);
    cmd_o.div_start = (state_r == S_FPS);
    cmd_o.emit      = (state_r == S_EMIT) && sts_i.out_free;
  end

  assign in_stall_o = (state_r != S_IDLE);

endmodule

>>> sv/render_statistics_counters_unit.sv
// Indirect, compute and ray tracing requests finish at their accept edge;
// a counted draw passes through the product multiplies, triangle multiply and accumulate.
// A frame boundary shows its snapshot after the smoothing step, the 27-step
// bit-serial divider for frames per second, and any wait for the output register.
// A new request is taken only once the last is finished; in_stall is high meanwhile.
// Reset (rst_n, synchronous, active low) clears all counters, the average and frame number.
`timescale 1ns / 1ps

module render_statistics_counters_unit import rscu_pkg::*; #(
  parameter int COUNTER_WIDTH = CNT_W_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  rscu_in_t         in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output rscu_out_t        out_data,
  input  logic             cfg_we,
  input  logic [WGT_W-1:0] cfg_wdata
);

  // The controller sequences each request; the datapath holds the counters,
  // the frame time average, the divider and the output register.
  rscu_cmd_t cmd;
  rscu_sts_t sts;

  rscu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid_i(in_valid),
    .in_stall_o(in_stall),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  // Counters are COUNTER_WIDTH bits wide and wrap; snapshot fields zero-extend them.
  rscu_dp #(
    .COUNTER_WIDTH(COUNTER_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .in_data_i  (in_data),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .out_stall_i(out_stall),
    .out_valid_o(out_valid),
    .out_data_o (out_data)
  );

endmodule
